// ----- rtl/sef_pkg.sv -----
// Shared types and constants for the slope envelope follower.
// Holds field widths, register codes, state and command types.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sef_pkg;

  // Channel counts: four input fields, and a design limit on active channels.
  localparam int IN_FIELDS    = 4;
  localparam int MAX_CHANNELS = 4;
  localparam int ACTIVE_MAX   = (MAX_CHANNELS < IN_FIELDS) ? MAX_CHANNELS : IN_FIELDS;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W + 1;
  localparam int FRAC_W     = 16;
  localparam int LEVEL_W    = 34;
  localparam int LEN_W      = 16;
  localparam int POS_W      = 16;
  localparam int SLOPE_W    = LEVEL_W + 1;
  localparam int NUM_W      = LEVEL_W + LEN_W;
  localparam int MODE_W     = 2;
  localparam int TRIG_W     = 2;
  localparam int CHAN_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // The divider retires two quotient bits per cycle.
  localparam int DIV_CNT_W = $clog2(NUM_W / 2 + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SLOPE  = DIV_CNT_W'(LEVEL_W / 2);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_INTERP = DIV_CNT_W'(NUM_W / 2);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [LEVEL_W-1:0] UNITY     = LEVEL_W'(64'd32768 << FRAC_W);

  // Detector modes. Code 3 is unused and behaves as the maximum.
  localparam logic [MODE_W-1:0] DET_MAX     = 2'd0;
  localparam logic [MODE_W-1:0] DET_TRIGGER = 2'd1;
  localparam logic [MODE_W-1:0] DET_SUM     = 2'd2;

  localparam logic [MODE_W-1:0] RESET_DETECT_MODE   = DET_MAX;
  localparam logic [TRIG_W-1:0] RESET_TRIGGER       = 2'd0;
  localparam logic [CHAN_W-1:0] RESET_CHANNEL_COUNT = 3'd2;
  localparam logic [LEN_W-1:0]  RESET_REACTION_LEN  = 16'd441;
  localparam logic [LEN_W-1:0]  RESET_DECAY_LEN     = 16'd4410;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_MODE     = 3'd0,
    CFG_TRIGGER_CHANNEL = 3'd1,
    CFG_CHANNEL_COUNT   = 3'd2,
    CFG_REACTION_LEN    = 3'd3,
    CFG_DECAY_LEN       = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_REACT,
    DIV_DECAY,
    DIV_INTERP
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOPE_GO,
    ST_SLOPE_WAIT,
    ST_DECIDE,
    ST_DECAY_GO,
    ST_DECAY_WAIT,
    ST_MUL_TGT,
    ST_MUL_START,
    ST_SUM,
    ST_INTERP_GO,
    ST_INTERP_WAIT,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic     accept;
    logic     div_go;
    div_sel_t div_sel;
    logic     decide;
    logic     slope_load;
    logic     mul_tgt;
    logic     mul_start;
    logic     num_add;
    logic     level_load;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rise;
    logic decay_restart;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sef_if.sv -----
// Valid/ready channel interfaces: input frames, result levels, register writes.
// Depends on sef_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sef_in_if import sef_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic signed [SAMPLE_W-1:0] sample_c;
  logic signed [SAMPLE_W-1:0] sample_d;

  modport source (output valid, output sample_a, output sample_b, output sample_c,
                  output sample_d, input ready);
  modport sink (input valid, input sample_a, input sample_b, input sample_c,
                input sample_d, output ready);
endinterface

interface sef_out_if import sef_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] envelope_level;

  modport source (output valid, output envelope_level, input ready);
  modport sink (input valid, input envelope_level, output ready);
endinterface

interface sef_cfg_if import sef_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sef_div.sv -----
// Restoring divider, two quotient bits per cycle, 50-bit dividend by 16 bits.
// Depends on sef_pkg for widths and step counts.
`timescale 1ns / 1ps
`default_nettype none

module sef_div import sef_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [NUM_W-1:0]     dividend,
  input  logic [LEN_W-1:0]     divisor,
  input  logic [DIV_CNT_W-1:0] steps,
  output logic [NUM_W-1:0]     quotient,
  output logic                 done
);

  logic [NUM_W-1:0]     dvd_r;
  logic [NUM_W-1:0]     quo_r;
  logic [LEN_W-1:0]     rem_r;
  logic [LEN_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [LEN_W:0] r1, r1s, r2, r2s;
  logic           q1, q2;

  // Two dependent compare-and-subtract steps on 17-bit values.
  always_comb begin
    r1  = {rem_r, dvd_r[NUM_W-1]};
    q1  = (r1 >= {1'b0, dsr_r});
    r1s = q1 ? (r1 - {1'b0, dsr_r}) : r1;
    r2  = {r1s[LEN_W-1:0], dvd_r[NUM_W-2]};
    q2  = (r2 >= {1'b0, dsr_r});
    r2s = q2 ? (r2 - {1'b0, dsr_r}) : r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dividend;
      quo_r <= '0;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NUM_W-3:0], 2'b00};
      quo_r <= {quo_r[NUM_W-3:0], q1, q2};
      rem_r <= r2s[LEN_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// ----- rtl/sef_dp.sv -----
// Datapath: configuration registers, detector, envelope state, multiplier,
// result register. Depends on sef_pkg and instantiates sef_div.
`timescale 1ns / 1ps
`default_nettype none

module sef_dp import sef_pkg::*; #(
  parameter int CHANNEL_LIMIT = MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   samples [IN_FIELDS],
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [LEVEL_W-1:0]    out_level,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  localparam int SUM_W = MAG_W + $clog2(IN_FIELDS);
  localparam int DET_W = SUM_W + FRAC_W;
  localparam int ACTIVE_LIMIT = (CHANNEL_LIMIT < IN_FIELDS) ? CHANNEL_LIMIT : IN_FIELDS;

  logic [MODE_W-1:0] detect_mode_r;
  logic [TRIG_W-1:0] trigger_channel_r;
  logic [CHAN_W-1:0] channel_count_r;
  logic [LEN_W-1:0]  reaction_len_r;
  logic [LEN_W-1:0]  decay_len_r;

  logic [LEVEL_W-1:0]        level_now_r;
  logic [LEVEL_W-1:0]        ramp_target_r;
  logic [LEVEL_W-1:0]        ramp_start_r;
  logic [LEN_W-1:0]          ramp_len_r;
  logic [POS_W-1:0]          ramp_pos_r;
  logic signed [SLOPE_W-1:0] ramp_slope_r;
  logic                      started_r;
  logic                      out_valid_r;

  logic [LEVEL_W-1:0] sample_r;
  logic               slope_neg_r;
  logic [NUM_W-1:0]   prod_r;
  logic [NUM_W-1:0]   num_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic [LEN_W-1:0]  react_eff, decay_eff;
  logic [CHAN_W-1:0] chans_eff;
  logic [TRIG_W-1:0] trig_eff;
  logic [MAG_W-1:0]  mag [IN_FIELDS];
  logic [MAG_W-1:0]  mag_max;
  logic [SUM_W-1:0]  mag_sum;
  logic [SUM_W-1:0]  det_mag;
  logic [DET_W-1:0]  det_wide;
  logic [LEVEL_W-1:0] det_level;

  logic               diff_neg;
  logic [LEVEL_W-1:0] diff_mag;

  logic [NUM_W-1:0]     div_dividend;
  logic [LEN_W-1:0]     div_divisor;
  logic [DIV_CNT_W-1:0] div_steps;
  logic [NUM_W-1:0]     div_quo;
  logic                 div_done;

  logic signed [SLOPE_W-1:0] quo_slope;
  logic                      rise, renew, seg_end;

  logic [LEVEL_W-1:0] mul_a;
  logic [LEN_W-1:0]   mul_b;
  logic [NUM_W-1:0]   mul_prod;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_mode_r     <= RESET_DETECT_MODE;
      trigger_channel_r <= RESET_TRIGGER;
      channel_count_r   <= RESET_CHANNEL_COUNT;
      reaction_len_r    <= RESET_REACTION_LEN;
      decay_len_r       <= RESET_DECAY_LEN;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DETECT_MODE:     detect_mode_r     <= cfg_data[MODE_W-1:0];
        CFG_TRIGGER_CHANNEL: trigger_channel_r <= cfg_data[TRIG_W-1:0];
        CFG_CHANNEL_COUNT:   channel_count_r   <= cfg_data[CHAN_W-1:0];
        CFG_REACTION_LEN:    reaction_len_r    <= cfg_data[LEN_W-1:0];
        CFG_DECAY_LEN:       decay_len_r       <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths of zero act as one; channel count and trigger are clipped.
  always_comb begin
    react_eff = (reaction_len_r == '0) ? LEN_W'(1) : reaction_len_r;
    decay_eff = (decay_len_r == '0) ? LEN_W'(1) : decay_len_r;
    if (channel_count_r == '0) begin
      chans_eff = CHAN_W'(1);
    end else if (channel_count_r > CHAN_W'(ACTIVE_LIMIT)) begin
      chans_eff = CHAN_W'(ACTIVE_LIMIT);
    end else begin
      chans_eff = channel_count_r;
    end
    if (CHAN_W'(trigger_channel_r) > chans_eff - CHAN_W'(1)) begin
      trig_eff = TRIG_W'(chans_eff - CHAN_W'(1));
    end else begin
      trig_eff = trigger_channel_r;
    end
  end

  // Detector over the active channels
  always_comb begin
    for (int i = 0; i < IN_FIELDS; i++) begin
      mag[i] = samples[i][SAMPLE_W-1] ? ((MAG_W'(1) << SAMPLE_W) - MAG_W'(samples[i]))
                                      : MAG_W'(samples[i]);
    end
    mag_max = '0;
    mag_sum = '0;
    for (int i = 0; i < IN_FIELDS; i++) begin
      if (CHAN_W'(i) < chans_eff) begin
        mag_sum = mag_sum + SUM_W'(mag[i]);
        if (mag[i] > mag_max) begin
          mag_max = mag[i];
        end
      end
    end
    case (detect_mode_r)
      DET_TRIGGER: det_mag = SUM_W'(mag[trig_eff]);
      DET_SUM:     det_mag = mag_sum;
      default:     det_mag = SUM_W'(mag_max);
    endcase
    det_wide  = {det_mag, {FRAC_W{1'b0}}};
    det_level = (det_wide > DET_W'(LEVEL_MAX)) ? LEVEL_MAX : det_wide[LEVEL_W-1:0];
  end

  // Distance from the current level to the new sample level
  always_comb begin
    diff_neg = (sample_r < level_now_r);
    diff_mag = diff_neg ? (level_now_r - sample_r) : (sample_r - level_now_r);
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_INTERP: begin
        div_dividend = num_r;
        div_divisor  = ramp_len_r;
        div_steps    = DIV_STEPS_INTERP;
      end
      DIV_DECAY: begin
        div_dividend = {diff_mag, {LEN_W{1'b0}}};
        div_divisor  = decay_eff;
        div_steps    = DIV_STEPS_SLOPE;
      end
      default: begin
        div_dividend = {diff_mag, {LEN_W{1'b0}}};
        div_divisor  = react_eff;
        div_steps    = DIV_STEPS_SLOPE;
      end
    endcase
  end

  sef_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Signed slope from the truncated quotient; a zero quotient stays non-negative.
  assign quo_slope = slope_neg_r ? -$signed({1'b0, div_quo[LEVEL_W-1:0]})
                                 : $signed({1'b0, div_quo[LEVEL_W-1:0]});

  always_comb begin
    rise    = (quo_slope >= ramp_slope_r) &&
              (!ramp_slope_r[SLOPE_W-1] || !quo_slope[SLOPE_W-1]);
    renew   = (sample_r > ramp_target_r) && ramp_slope_r[SLOPE_W-1];
    seg_end = !started_r || (ramp_pos_r >= ramp_len_r);
  end

  always_comb begin
    mul_a    = cmd.mul_start ? ramp_start_r : ramp_target_r;
    mul_b    = cmd.mul_start ? (ramp_len_r - ramp_pos_r) : ramp_pos_r;
    mul_prod = mul_a * mul_b;
  end

  // Envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_now_r   <= UNITY;
      ramp_target_r <= UNITY;
      ramp_start_r  <= UNITY;
      ramp_len_r    <= LEN_W'(1);
      ramp_pos_r    <= '0;
      ramp_slope_r  <= '0;
      started_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.decide && (rise || renew || seg_end)) begin
        ramp_target_r <= sample_r;
        ramp_start_r  <= level_now_r;
        ramp_pos_r    <= '0;
        ramp_len_r    <= rise ? react_eff : decay_eff;
        started_r     <= 1'b1;
        if (rise) begin
          ramp_slope_r <= quo_slope;
        end
      end
      if (cmd.slope_load) begin
        ramp_slope_r <= quo_slope;
      end
      if (cmd.level_load) begin
        level_now_r <= div_quo[LEVEL_W-1:0];
      end
      if (cmd.finish) begin
        ramp_pos_r  <= ramp_pos_r + POS_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= det_level;
    end
    if (cmd.div_go) begin
      slope_neg_r <= diff_neg;
    end
    if (cmd.mul_tgt) begin
      prod_r <= mul_prod;
    end
    if (cmd.mul_start) begin
      prod_r <= mul_prod;
      num_r  <= prod_r;
    end
    if (cmd.num_add) begin
      num_r <= num_r + prod_r;
    end
    if (cmd.finish) begin
      out_level_r <= level_now_r;
    end
  end

  always_comb begin
    stat.div_done      = div_done;
    stat.rise          = rise;
    stat.decay_restart = !rise && (renew || seg_end);
    stat.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

`ifndef NO_ASSERTIONS
  a_pos_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (ramp_pos_r <= ramp_len_r))
    else $error("ramp position ran past the segment length");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_len_r != '0)
    else $error("segment length is zero");

  a_interp_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.level_load |-> (div_done && (div_quo[NUM_W-1:LEVEL_W] == '0)))
    else $error("interpolated level does not fit the level width");
`endif

endmodule

`default_nettype wire

// ----- rtl/sef_ctrl.sv -----
// Controller state machine: sequences detection, slope divisions,
// interpolation and result hand-off. Depends on sef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sef_ctrl import sef_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SLOPE_GO;
        end
      end
      ST_SLOPE_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_REACT;
        state_nxt   = ST_SLOPE_WAIT;
      end
      ST_SLOPE_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.rise) begin
          state_nxt = ST_DONE;
        end else if (stat.decay_restart) begin
          state_nxt = ST_DECAY_GO;
        end else begin
          state_nxt = ST_MUL_TGT;
        end
      end
      ST_DECAY_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_DECAY;
        state_nxt   = ST_DECAY_WAIT;
      end
      ST_DECAY_WAIT: begin
        if (stat.div_done) begin
          cmd.slope_load = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_MUL_TGT: begin
        cmd.mul_tgt = 1'b1;
        state_nxt   = ST_MUL_START;
      end
      ST_MUL_START: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_SUM;
      end
      ST_SUM: begin
        cmd.num_add = 1'b1;
        state_nxt   = ST_INTERP_GO;
      end
      ST_INTERP_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_INTERP;
        state_nxt   = ST_INTERP_WAIT;
      end
      ST_INTERP_WAIT: begin
        cmd.div_sel = DIV_INTERP;
        if (stat.div_done) begin
          cmd.level_load = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == ST_SLOPE_WAIT || state_r == ST_DECAY_WAIT ||
                       state_r == ST_INTERP_WAIT))
    else $error("divider finished while no division was awaited");

  a_one_beat_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (!in_ready && state_r == ST_SLOPE_GO))
    else $error("accepted beat did not start the slope division");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !stat.out_free) |=> (state_r == ST_DONE))
    else $error("frame left the result state while the output was occupied");
`endif

endmodule

`default_nettype wire

// ----- rtl/slope_envelope_follower_unit.sv -----
// Top level of the slope envelope follower: channel plumbing around the
// controller and datapath. Depends on sef_pkg, sef_if, sef_ctrl and sef_dp.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// in_ch     sink       sample_a .. sample_d, one signed 16-bit sample per channel
// out_ch    source     envelope_level, 34 bits with 16 fractional bits
// cfg_ch    sink       index (register number) and data (register value)
//
// One frame at a time: its result is valid after the slope division for a rising
// ramp, after a second division for a decay ramp and after two products and the
// interpolation division otherwise; the next beat can be taken in the same cycle
// as the result becomes valid. The shared divider retires two quotient bits per cycle.
// Synchronous active-low reset puts the level and ramp end points at full scale.
// A stalled result waits in the output register; only the following result stalls.

module slope_envelope_follower_unit import sef_pkg::*; #(
  parameter int CHANNEL_LIMIT = MAX_CHANNELS
) (
  input logic        clk,
  input logic        rst_n,
  sef_in_if.sink     in_ch,
  sef_out_if.source  out_ch,
  sef_cfg_if.sink    cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [SAMPLE_W-1:0] samples [IN_FIELDS];
  logic                out_valid;
  logic [LEVEL_W-1:0]  out_level;
  logic                in_ready;

  // Channel fields map to channel numbers in order.
  assign samples[0] = in_ch.sample_a;
  assign samples[1] = in_ch.sample_b;
  assign samples[2] = in_ch.sample_c;
  assign samples[3] = in_ch.sample_d;

  // Register writes are taken at any time; the user must issue them only while idle, as the block does not enforce it.
  assign cfg_ch.ready = 1'b1;

  sef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sef_dp #(
    .CHANNEL_LIMIT (CHANNEL_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .samples   (samples),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_level (out_level),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.envelope_level = out_level;

endmodule

`default_nettype wire
